/* rtl/dfq_pkg.sv */
// Package: types, register map and reset constants of the detector fault qualifier.
package dfq_pkg;

    localparam int DETECTORS_DEFAULT = 64;

    localparam int ID_W    = 8;
    localparam int READ_W  = 16;
    localparam int CNT_W   = 7;
    localparam int RUN_W   = 8;
    localparam int ALARM_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 16;

    localparam logic [CNT_W-1:0] TEMP_COUNT_CAP = 7'd100;
    localparam logic [RUN_W-1:0] RUN_CAP        = 8'd255;

    localparam logic [READ_W-1:0]  TEMP_DIFF_LIMIT_RST     = 16'd10;
    localparam logic [CNT_W-1:0]   TEMP_PERSIST_COUNT_RST  = 7'd2;
    localparam logic [READ_W-1:0]  TEMP_MAX_RST            = 16'd165;
    localparam logic [READ_W-1:0]  CO_MAX_RST              = 16'd2000;
    localparam logic [READ_W-1:0]  VOC_MAX_RST             = 16'd3300;
    localparam logic [RUN_W-1:0]   ALARM_CONFIRM_COUNT_RST = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_DIFF_LIMIT     = 3'd0,
        REG_TEMP_PERSIST_COUNT  = 3'd1,
        REG_TEMP_MAX            = 3'd2,
        REG_CO_MAX              = 3'd3,
        REG_VOC_MAX             = 3'd4,
        REG_ALARM_CONFIRM_COUNT = 3'd5
    } dfq_reg_t;

    typedef enum logic {
        OP_CHECK = 1'b0,
        OP_QUERY = 1'b1
    } dfq_op_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } dfq_state_t;

    // One word of per-detector state, as stored in the RAM.
    typedef struct packed {
        logic [RUN_W-1:0] run;
        logic [CNT_W-1:0] cnt;
        logic             abnormal;
    } dfq_entry_t;

    localparam int ENTRY_W = $bits(dfq_entry_t);

endpackage

/* rtl/dfq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dfq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/detector_fault_qualifier_unit.sv */
// Top level: per-detector fault and alarm qualifier around one state RAM.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------------
//  s_*      | s_tvalid / s_tready  | s_tdata: detector_id, temperature,
//           |                      |   temp_reference, co_level, voc_level,
//           |                      |   alarm_level; s_tuser: opcode
//  m_*      | m_tvalid / m_tready  | m_tdata: id_valid, abnormal, alarm_out
//  cfg_*    | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// The accept cycle in ST_IDLE issues the RAM read; ST_UPDATE then reads the
// registered entry, updates it, writes it back and loads the result
// register, all of this in the same cycle.
// The result register holds a finished item while the next one is taken in;
// a stalled m_tready holds the update cycle until the register frees up.
// Reset clears a valid bit per detector, so entries read as zero until first
// written; no clearing pass is needed.
module detector_fault_qualifier_unit
    import dfq_pkg::*;
#(
    parameter int DETECTORS = DETECTORS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // detector_id[7:0], temperature[23:8], temp_reference[39:24],
    // co_level[55:40], voc_level[71:56], alarm_level[79:72]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // opcode[0]
    input  logic                  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // id_valid[0], abnormal[1], alarm_out[9:2], zero fill[15:10]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    localparam int IDX_W = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
    localparam logic [ID_W-1:0] ID_MAX = ID_W'(DETECTORS);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [READ_W-1:0] temp_diff_limit_reg;
    logic [CNT_W-1:0]  temp_persist_count_reg;
    logic [READ_W-1:0] temp_max_reg;
    logic [READ_W-1:0] co_max_reg;
    logic [READ_W-1:0] voc_max_reg;
    logic [RUN_W-1:0]  alarm_confirm_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_diff_limit_reg     <= TEMP_DIFF_LIMIT_RST;
            temp_persist_count_reg  <= TEMP_PERSIST_COUNT_RST;
            temp_max_reg            <= TEMP_MAX_RST;
            co_max_reg              <= CO_MAX_RST;
            voc_max_reg             <= VOC_MAX_RST;
            alarm_confirm_count_reg <= ALARM_CONFIRM_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Drop writes beyond the register list.
            unique case (dfq_reg_t'(cfg_index))
                REG_TEMP_DIFF_LIMIT:     temp_diff_limit_reg     <= cfg_data;
                REG_TEMP_PERSIST_COUNT:  temp_persist_count_reg  <= cfg_data[CNT_W-1:0];
                REG_TEMP_MAX:            temp_max_reg            <= cfg_data;
                REG_CO_MAX:              co_max_reg              <= cfg_data;
                REG_VOC_MAX:             voc_max_reg             <= cfg_data;
                REG_ALARM_CONFIRM_COUNT: alarm_confirm_count_reg <= cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input unpacking and id decode
    // ---------------------------------------------------------------
    logic [ID_W-1:0]  in_id;
    logic             in_id_ok;
    logic [IDX_W-1:0] in_idx;
    logic [ID_W-1:0]  in_id_m1;

    assign in_id    = s_tdata[7:0];
    assign in_id_ok = (in_id != '0) && (in_id <= ID_MAX);
    assign in_id_m1 = in_id - ID_W'(1);
    assign in_idx   = in_id_m1[IDX_W-1:0];

    // ---------------------------------------------------------------
    // Item hold registers
    // ---------------------------------------------------------------
    dfq_state_t        state_reg, state_next;
    logic              s_accept;
    logic              op_reg;
    logic              id_ok_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [READ_W-1:0] temp_reg;
    logic [READ_W-1:0] tref_reg;
    logic [READ_W-1:0] co_reg;
    logic [READ_W-1:0] voc_reg;
    logic [ALARM_W-1:0] alarm_reg;
    logic              hit_reg;
    logic [DETECTORS-1:0] valid_reg;

    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg    <= s_tuser;
            id_ok_reg <= in_id_ok;
            idx_reg   <= in_idx;
            temp_reg  <= s_tdata[23:8];
            tref_reg  <= s_tdata[39:24];
            co_reg    <= s_tdata[55:40];
            voc_reg   <= s_tdata[71:56];
            alarm_reg <= s_tdata[79:72];
            // Capture whether the entry has been written since reset.
            hit_reg   <= in_id_ok && valid_reg[in_idx];
        end
    end

    // ---------------------------------------------------------------
    // State RAM
    // ---------------------------------------------------------------
    logic       ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    dfq_entry_t old_entry;
    dfq_entry_t new_entry;

    dfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DETECTORS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (new_entry),
        .re    (s_accept && in_id_ok),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // Unwritten entries read as zero.
    assign old_entry = hit_reg ? dfq_entry_t'(ram_rdata) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Check update
    // ---------------------------------------------------------------
    logic [READ_W-1:0]  diff;
    logic [CNT_W-1:0]   cnt_new;
    logic               bad;
    logic [ALARM_W-1:0] alarm_gated;
    logic [RUN_W-1:0]   run_inc;
    logic [RUN_W-1:0]   run_new;
    logic [ALARM_W-1:0] alarm_q;

    always_comb
    begin
        diff = (temp_reg > tref_reg) ? (temp_reg - tref_reg) : (tref_reg - temp_reg);

        // Count consecutive suspicious checks, saturating at the cap.
        if (diff >= temp_diff_limit_reg)
        begin
            cnt_new = (old_entry.cnt < TEMP_COUNT_CAP) ? old_entry.cnt + CNT_W'(1)
                                                       : old_entry.cnt;
        end
        else
        begin
            cnt_new = '0;
        end

        bad = (temp_reg > temp_max_reg) || (co_reg > co_max_reg)
              || (voc_reg > voc_max_reg) || (cnt_new >= temp_persist_count_reg);

        // Mask the alarm of an abnormal detector.
        alarm_gated = bad ? '0 : alarm_reg;

        run_inc = (old_entry.run < RUN_CAP) ? old_entry.run + RUN_W'(1) : old_entry.run;
        if (alarm_gated != '0)
        begin
            if (run_inc >= alarm_confirm_count_reg)
            begin
                run_new = alarm_confirm_count_reg;
                alarm_q = alarm_gated;
            end
            else
            begin
                run_new = run_inc;
                alarm_q = '0;
            end
        end
        else
        begin
            run_new = '0;
            alarm_q = '0;
        end

        new_entry.run      = run_new;
        new_entry.cnt      = cnt_new;
        new_entry.abnormal = bad;
    end

    // ---------------------------------------------------------------
    // Control and result register
    // ---------------------------------------------------------------
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] result;
    logic                 out_free;
    logic                 load_out;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        result = '0;
        if (id_ok_reg)
        begin
            result[0] = 1'b1;
            if (dfq_op_t'(op_reg) == OP_QUERY)
            begin
                result[1] = old_entry.abnormal;
            end
            else
            begin
                result[1]   = bad;
                result[9:2] = alarm_q;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        load_out   = 1'b0;
        ram_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // Hold the item until the result register frees up.
                if (out_free)
                begin
                    load_out   = 1'b1;
                    ram_we     = id_ok_reg && (dfq_op_t'(op_reg) == OP_CHECK);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
